// File: hdl/cpb_pkg.sv
// ----------------------------------------------------------------------------
// cpb_pkg
// Shared types, widths, constants and helpers of the camera pose pipeline.
// ----------------------------------------------------------------------------
package cpb_pkg;

  localparam int N_ITER = 16;            // CORDIC steps, 8..24

  localparam int QW   = 35;              // matrix entries and yaw vectors
  localparam int VW   = 36;              // vectoring CORDIC x/y
  localparam int RW   = 34;              // rotation CORDIC x/y and residual
  localparam int PW   = 54;              // matrix entry times lever arm
  localparam int HW   = 34;              // unsaturated interaction point
  localparam int TW   = 23;              // rounded radial term
  localparam int SW   = 36;              // camera sums
  localparam int CFGW = 19;

  localparam int S_LEV  = 4;
  localparam int S_TRIG = 2 * N_ITER + 4;
  localparam int S_RAD  = S_TRIG + 1;
  localparam int LAT    = S_RAD + 1;

  localparam logic [7:0] REG_WAIST  = 8'd0;
  localparam logic [7:0] REG_HEIGHT = 8'd1;
  localparam logic [7:0] REG_ARM_FW = 8'd2;
  localparam logic [7:0] REG_ARM_UP = 8'd3;

  localparam logic [17:0] WAIST_RST  = 18'd14418;
  localparam logic [18:0] HEIGHT_RST = 19'h7CF5C;   // -12452
  localparam logic [18:0] ARM_FW_RST = 19'd31457;
  localparam logic [18:0] ARM_UP_RST = 19'd9830;

  localparam logic [31:0] QUARTER   = 32'h4000_0000;
  localparam logic [31:0] NEG_QUART = 32'hC000_0000;
  localparam logic signed [RW-1:0] GAIN = RW'(652032874);

  typedef struct packed {
    logic signed [31:0] base_px;
    logic signed [31:0] base_py;
    logic signed [31:0] base_pz;
    logic signed [15:0] base_qw;
    logic signed [15:0] base_qx;
    logic signed [15:0] base_qy;
    logic signed [15:0] base_qz;
    logic signed [15:0] cam_qw;
    logic signed [15:0] cam_qx;
    logic signed [15:0] cam_qy;
    logic signed [15:0] cam_qz;
  } in_t;

  typedef struct packed {
    logic signed [31:0] contact_px;
    logic signed [31:0] contact_py;
    logic signed [31:0] contact_pz;
    logic        [14:0] heading_qw;
    logic signed [15:0] heading_qz;
    logic signed [31:0] camera_px;
    logic signed [31:0] camera_py;
    logic signed [31:0] camera_pz;
  } out_t;

  typedef struct packed {
    logic signed [QW-1:0] r00;
    logic signed [QW-1:0] r02;
    logic signed [QW-1:0] r10;
    logic signed [QW-1:0] r12;
    logic signed [QW-1:0] r20;
    logic signed [QW-1:0] r22;
    logic signed [QW-1:0] bvx;
    logic signed [QW-1:0] bvy;
    logic signed [QW-1:0] cvx;
    logic signed [QW-1:0] cvy;
  } qout_t;

  function automatic logic [31:0] atan_ent(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic [31:0] r;
    if (v > SW'(64'sd2147483647)) r = 32'h7FFF_FFFF;
    else if (v < -SW'(64'sd2147483648)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hdl/cpb_quat.sv
// ----------------------------------------------------------------------------
// cpb_quat
// Two stages: component products, then rotation matrix entries and yaw vectors.
// ----------------------------------------------------------------------------
module cpb_quat (
  input  logic          clk,
  input  logic          en,
  input  cpb_pkg::in_t  din,
  output cpb_pkg::qout_t dout
);

  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [31:0] cww_r, cxx_r, cyy_r, czz_r, cxy_r, cwz_r;
  cpb_pkg::qout_t q_r;

  localparam logic signed [cpb_pkg::QW-1:0] ONE = cpb_pkg::QW'(268435456);

  function automatic logic signed [cpb_pkg::QW-1:0] ex(input logic signed [31:0] v);
    return cpb_pkg::QW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r  <= din.base_qw * din.base_qw;
      xx_r  <= din.base_qx * din.base_qx;
      yy_r  <= din.base_qy * din.base_qy;
      zz_r  <= din.base_qz * din.base_qz;
      xy_r  <= din.base_qx * din.base_qy;
      wz_r  <= din.base_qw * din.base_qz;
      xz_r  <= din.base_qx * din.base_qz;
      wy_r  <= din.base_qw * din.base_qy;
      yz_r  <= din.base_qy * din.base_qz;
      wx_r  <= din.base_qw * din.base_qx;
      cww_r <= din.cam_qw * din.cam_qw;
      cxx_r <= din.cam_qx * din.cam_qx;
      cyy_r <= din.cam_qy * din.cam_qy;
      czz_r <= din.cam_qz * din.cam_qz;
      cxy_r <= din.cam_qx * din.cam_qy;
      cwz_r <= din.cam_qw * din.cam_qz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.r00 <= ONE - ((ex(yy_r) + ex(zz_r)) <<< 1);
      q_r.r02 <= (ex(xz_r) + ex(wy_r)) <<< 1;
      q_r.r10 <= (ex(xy_r) + ex(wz_r)) <<< 1;
      q_r.r12 <= (ex(yz_r) - ex(wx_r)) <<< 1;
      q_r.r20 <= (ex(xz_r) - ex(wy_r)) <<< 1;
      q_r.r22 <= ONE - ((ex(xx_r) + ex(yy_r)) <<< 1);
      q_r.bvx <= ex(ww_r) + ex(xx_r) - ex(yy_r) - ex(zz_r);
      q_r.bvy <= (ex(xy_r) + ex(wz_r)) <<< 1;
      q_r.cvx <= ex(cww_r) + ex(cxx_r) - ex(cyy_r) - ex(czz_r);
      q_r.cvy <= (ex(cxy_r) + ex(cwz_r)) <<< 1;
    end
  end

  assign dout = q_r;

endmodule

// File: hdl/cpb_vec.sv
// ----------------------------------------------------------------------------
// cpb_vec
// Vectoring CORDIC, one step per stage: yaw of (vx, vy) as a binary angle.
// ----------------------------------------------------------------------------
module cpb_vec (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [cpb_pkg::QW-1:0]    vx,
  input  logic signed [cpb_pkg::QW-1:0]    vy,
  output logic signed [31:0]               yaw
);

  localparam int N  = cpb_pkg::N_ITER;
  localparam int VW = cpb_pkg::VW;

  logic signed [VW-1:0] x_r [0:N];
  logic signed [VW-1:0] y_r [0:N];
  logic        [31:0]   a_r [0:N];
  logic                 z_r [0:N];

  logic signed [VW-1:0] ex, ey;
  assign ex = VW'(vx);
  assign ey = VW'(vy);

  // quarter-turn pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= (vx == '0) && (vy == '0);
      if (ex < 0) begin
        if (ey >= 0) begin
          x_r[0] <= ey;
          y_r[0] <= -ex;
          a_r[0] <= cpb_pkg::QUARTER;
        end else begin
          x_r[0] <= -ey;
          y_r[0] <= ex;
          a_r[0] <= cpb_pkg::NEG_QUART;
        end
      end else begin
        x_r[0] <= ex;
        y_r[0] <= ey;
        a_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        z_r[i+1] <= z_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] + cpb_pkg::atan_ent(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] - cpb_pkg::atan_ent(i);
        end
      end
    end
  end

  // zero vector has no direction: yaw reads as zero
  assign yaw = z_r[N] ? 32'sd0 : $signed(a_r[N]);

endmodule

// File: hdl/cpb_rot.sv
// ----------------------------------------------------------------------------
// cpb_rot
// Rotation CORDIC, one step per stage: cosine and sine of a binary angle, Q.30.
// ----------------------------------------------------------------------------
module cpb_rot (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [31:0]            ang,
  output logic signed [cpb_pkg::RW-1:0] cos_o,
  output logic signed [cpb_pkg::RW-1:0] sin_o
);

  localparam int N  = cpb_pkg::N_ITER;
  localparam int RW = cpb_pkg::RW;

  logic signed [RW-1:0] x_r [0:N];
  logic signed [RW-1:0] y_r [0:N];
  logic signed [RW-1:0] r_r [0:N];

  logic signed [RW-1:0] a, q;
  assign a = RW'(ang);
  assign q = RW'(cpb_pkg::QUARTER);

  always_ff @(posedge clk) begin
    if (en) begin
      if (a > q) begin
        x_r[0] <= '0;
        y_r[0] <= cpb_pkg::GAIN;
        r_r[0] <= a - q;
      end else if (a < -q) begin
        x_r[0] <= '0;
        y_r[0] <= -cpb_pkg::GAIN;
        r_r[0] <= a + q;
      end else begin
        x_r[0] <= cpb_pkg::GAIN;
        y_r[0] <= '0;
        r_r[0] <= a;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (r_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          r_r[i+1] <= r_r[i] - RW'(cpb_pkg::atan_ent(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          r_r[i+1] <= r_r[i] + RW'(cpb_pkg::atan_ent(i));
        end
      end
    end
  end

  assign cos_o = x_r[N];
  assign sin_o = y_r[N];

endmodule

// File: hdl/camera_pose_from_base_pose.sv
// ----------------------------------------------------------------------------
// camera_pose_from_base_pose
// Interaction point, heading quaternion and camera position from a base pose.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one pose item; out_valid/out_ready/out_data
//   carry one result item per pose. cfg_we/cfg_idx/cfg_data write the waist
//   diameter, height offset and the two lever arm components, one register per
//   write; write them only while no item is in flight.
//   The pipeline has two quaternion stages (products, then matrix entries),
//   a vectoring CORDIC and a rotation CORDIC of N_ITER+1 stages each, then a
//   radial multiply stage and the output register.
//   Throughput is one item per cycle unless the output stalls; every stage
//   holds one item. When the receiver stalls with a result waiting, the whole
//   pipeline holds and in_ready drops; nothing is dropped or repeated.
//   Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module camera_pose_from_base_pose (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cpb_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cpb_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [7:0]                 cfg_idx,
  input  logic [cpb_pkg::CFGW-1:0]   cfg_data
);

  localparam int LAT   = cpb_pkg::LAT;
  localparam int S_LEV = cpb_pkg::S_LEV;
  localparam int S_RAD = cpb_pkg::S_RAD;
  localparam int PW    = cpb_pkg::PW;
  localparam int HW    = cpb_pkg::HW;
  localparam int RW    = cpb_pkg::RW;
  localparam int TW    = cpb_pkg::TW;
  localparam int SW    = cpb_pkg::SW;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } pos_t;

  typedef struct packed {
    logic signed [HW-1:0] hx;
    logic signed [HW-1:0] hy;
    logic signed [HW-1:0] hz;
  } hpos_t;

  logic [17:0] waist_r;
  logic [18:0] height_r, armf_r, armu_r;

  logic [LAT:1] vld_r;
  logic         adv;

  assign adv      = !vld_r[LAT] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waist_r  <= cpb_pkg::WAIST_RST;
      height_r <= cpb_pkg::HEIGHT_RST;
      armf_r   <= cpb_pkg::ARM_FW_RST;
      armu_r   <= cpb_pkg::ARM_UP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        cpb_pkg::REG_WAIST:  waist_r  <= cfg_data[17:0];
        cpb_pkg::REG_HEIGHT: height_r <= cfg_data;
        cpb_pkg::REG_ARM_FW: armf_r   <= cfg_data;
        cpb_pkg::REG_ARM_UP: armu_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  // quaternion products and matrix
  cpb_pkg::qout_t q;
  cpb_quat u_quat (.clk(clk), .en(adv), .din(in_data), .dout(q));

  // position travels beside the matrix
  pos_t pos_r [1:3];
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r[1] <= '{px: in_data.base_px, py: in_data.base_py, pz: in_data.base_pz};
      pos_r[2] <= pos_r[1];
      pos_r[3] <= pos_r[2];
    end
  end

  // lever arm: products, then rounded sums plus position
  logic signed [PW-1:0] m00_r, m02_r, m10_r, m12_r, m20_r, m22_r;
  logic signed [18:0]   ax, az;
  assign ax = $signed(armf_r);
  assign az = $signed(armu_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      m00_r <= PW'(q.r00 * ax);
      m02_r <= PW'(q.r02 * az);
      m10_r <= PW'(q.r10 * ax);
      m12_r <= PW'(q.r12 * az);
      m20_r <= PW'(q.r20 * ax);
      m22_r <= PW'(q.r22 * az);
    end
  end

  function automatic logic signed [HW-1:0] lever(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b,
                                                 input logic signed [31:0] p);
    logic signed [PW:0] s;
    s = (PW'(a) + (PW+1)'(b)) + ((PW+1)'(1) <<< 27);
    s = s >>> 28;
    return HW'(s) + HW'(p);
  endfunction

  hpos_t hd_r [S_LEV:LAT-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      hd_r[S_LEV].hx <= lever(m00_r, m02_r, pos_r[3].px);
      hd_r[S_LEV].hy <= lever(m10_r, m12_r, pos_r[3].py);
      hd_r[S_LEV].hz <= lever(m20_r, m22_r, pos_r[3].pz);
    end
  end

  for (genvar k = S_LEV + 1; k <= LAT - 1; k++) begin : g_hd
    always_ff @(posedge clk) begin
      if (adv) hd_r[k] <= hd_r[k-1];
    end
  end

  // yaw and trig
  logic signed [31:0]   byaw, cyaw, hyaw;
  logic signed [RW-1:0] yc, ys, hc, hs, kc, ks;

  cpb_vec u_bvec (.clk(clk), .en(adv), .vx(q.bvx), .vy(q.bvy), .yaw(byaw));
  cpb_vec u_cvec (.clk(clk), .en(adv), .vx(q.cvx), .vy(q.cvy), .yaw(cyaw));

  assign hyaw = byaw >>> 1;

  cpb_rot u_brot (.clk(clk), .en(adv), .ang(byaw), .cos_o(yc), .sin_o(ys));
  cpb_rot u_hrot (.clk(clk), .en(adv), .ang(hyaw), .cos_o(hc), .sin_o(hs));
  cpb_rot u_crot (.clk(clk), .en(adv), .ang(cyaw), .cos_o(kc), .sin_o(ks));

  // radial terms and heading
  logic signed [18:0] wd;
  assign wd = $signed({1'b0, waist_r});

  function automatic logic signed [TW-1:0] radial(input logic signed [18:0] w,
                                                  input logic signed [RW-1:0] t);
    logic signed [RW+18:0] p;
    p = (w * t) + ((RW+19)'(1) <<< 30);
    p = p >>> 31;
    return TW'(p);
  endfunction

  logic signed [TW-1:0] tyc_r, tys_r, tkc_r, tks_r;
  logic        [14:0]   hqw_r;
  logic signed [15:0]   hqz_r;
  logic signed [RW-1:0] hcr, hsr;

  assign hcr = (hc + RW'(32768)) >>> 16;
  assign hsr = (hs + RW'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (adv) begin
      tyc_r <= radial(wd, yc);
      tys_r <= radial(wd, ys);
      tkc_r <= radial(wd, kc);
      tks_r <= radial(wd, ks);
      if (hcr < 0) hqw_r <= '0;
      else if (hcr > RW'(16384)) hqw_r <= 15'd16384;
      else hqw_r <= hcr[14:0];
      if (hsr < -RW'(16384)) hqz_r <= -16'sd16384;
      else if (hsr > RW'(16384)) hqz_r <= 16'sd16384;
      else hqz_r <= hsr[15:0];
    end
  end

  // output register
  cpb_pkg::out_t o_r;
  hpos_t         hf;
  assign hf = hd_r[LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r.contact_px <= cpb_pkg::sat32(SW'(hf.hx));
      o_r.contact_py <= cpb_pkg::sat32(SW'(hf.hy));
      o_r.contact_pz <= cpb_pkg::sat32(SW'(hf.hz));
      o_r.heading_qw <= hqw_r;
      o_r.heading_qz <= hqz_r;
      o_r.camera_px  <= cpb_pkg::sat32(SW'(hf.hx) + SW'(tyc_r) + SW'(tkc_r));
      o_r.camera_py  <= cpb_pkg::sat32(SW'(hf.hy) + SW'(tys_r) + SW'(tks_r));
      o_r.camera_pz  <= cpb_pkg::sat32(SW'(hf.hz) + SW'($signed(height_r)));
    end
  end

  assign out_valid = vld_r[LAT];
  assign out_data  = o_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");
  a_hqw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.heading_qw <= 15'd16384)
    else $error("heading_qw out of range");
  a_hqz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.heading_qz <= 16'sd16384 &&
                   out_data.heading_qz >= -16'sd16384))
    else $error("heading_qz out of range");
  a_rad: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[S_RAD] |=> out_valid)
    else $error("item lost at output stage");
`endif

endmodule
